/* rtl/pidpi_pkg.sv */
// Shared widths, register codes and the configuration record of the PID controller.
`default_nettype none

package pidpi_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int GAIN_FRAC_BITS = 16;

	localparam int GAIN_W   = 24;
	localparam int LIMIT_W  = 31;
	localparam int THRESH_W = 16;
	localparam int DRIVE_W  = 32;
	localparam int SUM_W    = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Error and derived operand widths
	localparam int ERR_W   = SAMPLE_BITS + 1;
	localparam int MAG_W   = (ERR_W > THRESH_W) ? ERR_W : THRESH_W;
	localparam int OP_P_W  = ERR_W + 1;
	localparam int OP_D_W  = ERR_W + 2;
	localparam int OP_I_W  = (ERR_W > SUM_W) ? ERR_W : SUM_W;
	localparam int SUMX_W  = OP_I_W + 1;

	// Product, accumulator and rounded widths
	localparam int PROD_P_W = GAIN_W + OP_P_W;
	localparam int PROD_I_W = GAIN_W + OP_I_W;
	localparam int PROD_D_W = GAIN_W + OP_D_W;
	localparam int ACC_W    = PROD_I_W + 2;
	localparam int RND_W    = ACC_W - GAIN_FRAC_BITS;
	localparam int Y_W      = ((RND_W > DRIVE_W) ? RND_W : DRIVE_W) + 1;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_THRESH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = 3'd6;

	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = '1;
	localparam logic [THRESH_W-1:0] THRESH_RESET = '1;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       output_limit;
		logic [LIMIT_W-1:0]       integral_limit;
		logic [THRESH_W-1:0]      sep_threshold;
		logic                     loop_mode;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/pidpi_if.sv */
// Request, response and configuration channel interfaces of the PID controller.
`default_nettype none

interface pidpi_req_if;
	import pidpi_pkg::*;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [SAMPLE_BITS-1:0] setpoint;
	logic signed [SAMPLE_BITS-1:0] measured;
	modport source (output valid, command, setpoint, measured, input ready);
	modport sink (input valid, command, setpoint, measured, output ready);
endinterface

interface pidpi_rsp_if;
	import pidpi_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      clamped;
	modport source (output valid, drive, clamped, input ready);
	modport sink (input valid, drive, clamped, output ready);
endinterface

interface pidpi_cfg_if;
	import pidpi_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/pidpi_cfg.sv */
// Configuration register file of the PID controller.
`default_nettype none

module pidpi_cfg (
	input  logic             clk,
	input  logic             arst_n,
	pidpi_cfg_if.sink        cfg,
	output pidpi_pkg::cfg_t  regs
);
	import pidpi_pkg::*;

	cfg_t regs_q;
	logic wr_en;

	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid && cfg.ready;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_p         <= '0;
			regs_q.gain_i         <= '0;
			regs_q.gain_d         <= '0;
			regs_q.output_limit   <= LIMIT_RESET;
			regs_q.integral_limit <= LIMIT_RESET;
			regs_q.sep_threshold  <= THRESH_RESET;
			regs_q.loop_mode      <= MODE_POSITIONAL;
		end else if (wr_en) begin
			unique case (cfg.index)
				REG_GAIN_P:     regs_q.gain_p         <= cfg.data[GAIN_W-1:0];
				REG_GAIN_I:     regs_q.gain_i         <= cfg.data[GAIN_W-1:0];
				REG_GAIN_D:     regs_q.gain_d         <= cfg.data[GAIN_W-1:0];
				REG_OUT_LIMIT:  regs_q.output_limit   <= cfg.data[LIMIT_W-1:0];
				REG_INT_LIMIT:  regs_q.integral_limit <= cfg.data[LIMIT_W-1:0];
				REG_SEP_THRESH: regs_q.sep_threshold  <= cfg.data[THRESH_W-1:0];
				REG_LOOP_MODE:  regs_q.loop_mode      <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/pid_positional_incremental.sv */
// Discrete PID controller, positional or incremental form, four-stage pipeline.
// A request passes the stage 1 to 4 registers and then the output register before its result is offered.
// Throughput: one request per cycle; a stage holds only while the one after it is full and held.
// The error sum recurrence sits in stage 1, the held-output recurrence in stage 4,
// so the three gain multiplies run between registers with no feedback around them.
// Reset clears pipeline valids, history, error sum and held output; registers take defaults.
`default_nettype none

module pid_positional_incremental (
	input  logic          clk,
	input  logic          arst_n,
	pidpi_req_if.sink     req,
	pidpi_rsp_if.source   rsp,
	pidpi_cfg_if.sink     cfg
);
	import pidpi_pkg::*;

	cfg_t regs;

	pidpi_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Handshake chain
	logic v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;
	logic acc_in, adv1, adv2, adv3, adv4;

	assign rdy_out = !v_out_q || rsp.ready;
	assign rdy4    = !v_s4 || rdy_out;
	assign rdy3    = !v_s3 || rdy4;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign adv4    = v_s4 && rdy_out;
	assign adv3    = v_s3 && rdy4;
	assign adv2    = v_s2 && rdy3;
	assign adv1    = v_s1 && rdy2;
	assign acc_in  = req.valid && rdy1;
	assign req.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1    <= req.valid;
			if (rdy2)    v_s2    <= v_s1;
			if (rdy3)    v_s3    <= v_s2;
			if (rdy4)    v_s4    <= v_s3;
			if (rdy_out) v_out_q <= v_s4;
		end
	end

	// Stage 1: input register, error, history and error sum
	logic                          cmd_s1;
	logic signed [SAMPLE_BITS-1:0] sp_s1, ms_s1;

	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_s1 <= req.command;
			sp_s1  <= req.setpoint;
			ms_s1  <= req.measured;
		end
	end

	logic signed [SAMPLE_BITS-1:0] last_measured_q;
	logic signed [ERR_W-1:0]       error_prev_q, error_prev2_q;
	logic signed [SUM_W-1:0]       error_sum_q;

	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         err_mag;
	logic                     in_band;
	logic signed [SUMX_W-1:0] sum_raw, lim_i, sum_sat;
	logic signed [SUM_W-1:0]  error_sum_nxt;
	logic signed [OP_P_W-1:0] op_p;
	logic signed [OP_I_W-1:0] op_i;
	logic signed [OP_D_W-1:0] op_d;

	always_comb begin
		err     = ERR_W'(sp_s1) - ERR_W'(ms_s1);
		err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		in_band = MAG_W'(err_mag) < MAG_W'(regs.sep_threshold);
		sum_raw = SUMX_W'(error_sum_q) + SUMX_W'(err);
		lim_i   = SUMX_W'(regs.integral_limit);
		if (sum_raw > lim_i)
			sum_sat = lim_i;
		else if (sum_raw < -lim_i)
			sum_sat = -lim_i;
		else
			sum_sat = sum_raw;
		error_sum_nxt = in_band ? SUM_W'(sum_sat) : '0;

		if (regs.loop_mode == MODE_INCREMENTAL) begin
			op_p = OP_P_W'(err) - OP_P_W'(error_prev_q);
			op_i = OP_I_W'(err);
			op_d = OP_D_W'(err) - (OP_D_W'(error_prev_q) <<< 1) + OP_D_W'(error_prev2_q);
		end else begin
			op_p = OP_P_W'(err);
			op_i = OP_I_W'(error_sum_nxt);
			// derivative on measurement, negated here
			op_d = OP_D_W'(last_measured_q) - OP_D_W'(ms_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_measured_q <= '0;
			error_prev_q    <= '0;
			error_prev2_q   <= '0;
			error_sum_q     <= '0;
		end else if (adv1) begin
			if (cmd_s1 == CMD_CLEAR) begin
				last_measured_q <= '0;
				error_prev_q    <= '0;
				error_prev2_q   <= '0;
				error_sum_q     <= '0;
			end else begin
				last_measured_q <= ms_s1;
				error_prev_q    <= err;
				error_prev2_q   <= error_prev_q;
				// error sum moves only in positional form
				if (regs.loop_mode == MODE_POSITIONAL)
					error_sum_q <= error_sum_nxt;
			end
		end
	end

	// Stage 2: operands, gain multiplies
	logic                     cmd_s2;
	logic signed [OP_P_W-1:0] op_p_s2;
	logic signed [OP_I_W-1:0] op_i_s2;
	logic signed [OP_D_W-1:0] op_d_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s2  <= cmd_s1;
			op_p_s2 <= op_p;
			op_i_s2 <= op_i;
			op_d_s2 <= op_d;
		end
	end

	logic signed [PROD_P_W-1:0] prod_p;
	logic signed [PROD_I_W-1:0] prod_i;
	logic signed [PROD_D_W-1:0] prod_d;

	assign prod_p = PROD_P_W'(op_p_s2) * PROD_P_W'(regs.gain_p);
	assign prod_i = PROD_I_W'(op_i_s2) * PROD_I_W'(regs.gain_i);
	assign prod_d = PROD_D_W'(op_d_s2) * PROD_D_W'(regs.gain_d);

	// Stage 3: products, sum and round half up
	logic                       cmd_s3;
	logic signed [PROD_P_W-1:0] prod_p_s3;
	logic signed [PROD_I_W-1:0] prod_i_s3;
	logic signed [PROD_D_W-1:0] prod_d_s3;

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s3    <= cmd_s2;
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
		end
	end

	logic signed [ACC_W-1:0] acc;
	logic signed [RND_W-1:0] rnd;

	assign acc = ACC_W'(prod_p_s3) + ACC_W'(prod_i_s3) + ACC_W'(prod_d_s3) + ROUND_HALF;
	assign rnd = acc[ACC_W-1:GAIN_FRAC_BITS];

	// Stage 4: held output, clamp
	logic                    cmd_s4;
	logic signed [RND_W-1:0] rnd_s4;

	always_ff @(posedge clk) begin
		if (adv3) begin
			cmd_s4 <= cmd_s3;
			rnd_s4 <= rnd;
		end
	end

	logic signed [DRIVE_W-1:0] held_q;
	logic signed [Y_W-1:0]     y_raw, lim_o, y_sat;
	logic                      clip;
	logic signed [DRIVE_W-1:0] drive_nxt;
	logic                      clamped_nxt;

	always_comb begin
		y_raw = Y_W'(rnd_s4);
		if (regs.loop_mode == MODE_INCREMENTAL)
			y_raw = y_raw + Y_W'(held_q);
		lim_o = Y_W'(regs.output_limit);
		clip  = 1'b1;
		if (y_raw > lim_o)
			y_sat = lim_o;
		else if (y_raw < -lim_o)
			y_sat = -lim_o;
		else begin
			y_sat = y_raw;
			clip  = 1'b0;
		end
		if (cmd_s4 == CMD_CLEAR) begin
			drive_nxt   = '0;
			clamped_nxt = 1'b0;
		end else begin
			drive_nxt   = DRIVE_W'(y_sat);
			clamped_nxt = clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (adv4)
			held_q <= drive_nxt;
	end

	// Output register
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      clamped_q;

	always_ff @(posedge clk) begin
		if (adv4) begin
			drive_q   <= drive_nxt;
			clamped_q <= clamped_nxt;
		end
	end

	assign rsp.valid   = v_out_q;
	assign rsp.drive   = drive_q;
	assign rsp.clamped = clamped_q;

	logic signed [DRIVE_W-1:0] lim_drive;
	assign lim_drive = DRIVE_W'(regs.output_limit);

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv4 && cmd_s4 == CMD_CLEAR) |=> (rsp.drive == '0 && !rsp.clamped && held_q == '0))
		else $error("clear request did not give a zero result");

	a_held_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv4 |=> (held_q == rsp.drive))
		else $error("held output differs from the delivered drive");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.clamped) |-> (rsp.drive == lim_drive || rsp.drive == -lim_drive))
		else $error("clamp flag set with drive off the limit");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy_out) |=> (v_s4 && $stable(rnd_s4) && $stable(cmd_s4)))
		else $error("stage 4 lost its request while stalled");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking regression bench for the positional/incremental PID controller.
`default_nettype none

module tb_top;
	import pidpi_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam longint ROUND_BIAS     = longint'(1) << (GAIN_FRAC_BITS - 1);
	localparam int     QUIET_LIMIT    = 2000;
	localparam int     RANDOM_ITEMS   = 1225;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      clamped;
	} pid_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pidpi_req_if req ();
	pidpi_rsp_if rsp ();
	pidpi_cfg_if cfg ();

	pid_positional_incremental dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Controller image: register file and history
	cfg_t   active_cfg;
	longint last_meas, err_prev1, err_prev2, err_sum, held_drive;

	pid_result_t pending_drives [$];
	pid_result_t oldest;

	bit sender_idle, receiver_idle, req_held;
	int stall_left;
	int fault_count, requests_sent, clears_sent, results_checked, cfg_loads, incr_loads;
	int quiet_cycles;

	function automatic pid_result_t advance_pid(input logic cmd,
			input logic signed [SAMPLE_BITS-1:0] sp, input logic signed [SAMPLE_BITS-1:0] ms);
		pid_result_t r;
		longint s, m, e, kp, ki, kd, lim, acc, y, total;
		r = '0;
		if (cmd == CMD_CLEAR) begin
			last_meas = 0;
			err_prev1 = 0;
			err_prev2 = 0;
			err_sum = 0;
			held_drive = 0;
			return r;
		end
		s = sp;
		m = ms;
		e = s - m;
		kp = active_cfg.gain_p;
		ki = active_cfg.gain_i;
		kd = active_cfg.gain_d;
		if (active_cfg.loop_mode == MODE_POSITIONAL) begin
			lim = active_cfg.integral_limit;
			// integrate only inside the separation band, otherwise drop the sum
			if ((e < 0 ? -e : e) < longint'(active_cfg.sep_threshold)) begin
				total = err_sum + e;
				if (total > lim)
					total = lim;
				else if (total < -lim)
					total = -lim;
				err_sum = total;
			end else begin
				err_sum = 0;
			end
			acc = kp * e + ki * err_sum - kd * (m - last_meas);
			y = (acc + ROUND_BIAS) >>> GAIN_FRAC_BITS;
		end else begin
			acc = kp * (e - err_prev1) + ki * e + kd * (e - 2 * err_prev1 + err_prev2);
			y = held_drive + ((acc + ROUND_BIAS) >>> GAIN_FRAC_BITS);
		end
		lim = active_cfg.output_limit;
		if (y > lim) begin
			y = lim;
			r.clamped = 1'b1;
		end else if (y < -lim) begin
			y = -lim;
			r.clamped = 1'b1;
		end
		held_drive = y;
		last_meas = m;
		err_prev2 = err_prev1;
		err_prev1 = e;
		r.drive = y[DRIVE_W-1:0];
		return r;
	endfunction

	function automatic cfg_t make_settings(input logic signed [GAIN_W-1:0] kp,
			input logic signed [GAIN_W-1:0] ki, input logic signed [GAIN_W-1:0] kd,
			input logic [LIMIT_W-1:0] olim, input logic [LIMIT_W-1:0] ilim,
			input logic [THRESH_W-1:0] thr, input logic mode);
		cfg_t c;
		c.gain_p = kp;
		c.gain_i = ki;
		c.gain_d = kd;
		c.output_limit = olim;
		c.integral_limit = ilim;
		c.sep_threshold = thr;
		c.loop_mode = mode;
		return c;
	endfunction

	// Mostly short pauses, now and then a long one
	function automatic int draw_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(5, 24);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return SAMPLE_BITS'(int'($urandom_range(0, 600)) - 300);
		else if (r < 85)
			return SAMPLE_BITS'($urandom);
		case ($urandom_range(0, 3))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	function automatic logic signed [GAIN_W-1:0] rand_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return GAIN_W'(int'($urandom_range(0, 262144)) - 131072);
		else if (r < 80)
			return GAIN_W'($urandom);
		case ($urandom_range(0, 2))
			0: return 24'sh800000;
			1: return 24'sh7FFFFF;
			default: return 24'sh000000;
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] rand_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return '1;
		else if (r < 40)
			return '0;
		else if (r < 70)
			return LIMIT_W'($urandom_range(0, 100000));
		return LIMIT_W'($urandom);
	endfunction

	task automatic send_request(input logic cmd, input logic signed [SAMPLE_BITS-1:0] sp,
			input logic signed [SAMPLE_BITS-1:0] ms);
		int pause;
		pause = sender_idle ? draw_pause() : 0;
		if (pause > 0 && req_held) begin
			req.valid <= 1'b0;
			req_held = 1'b0;
		end
		repeat (pause) @(posedge clk);
		req.valid <= 1'b1;
		req_held = 1'b1;
		req.command <= cmd;
		req.setpoint <= sp;
		req.measured <= ms;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_drives.push_back(advance_pid(cmd, sp, ms));
		requests_sent++;
		if (cmd == CMD_CLEAR)
			clears_sent++;
	endtask

	// Hold the request side until every outstanding result is back
	task automatic wait_drained();
		if (req_held) begin
			req.valid <= 1'b0;
			req_held = 1'b0;
		end
		while (pending_drives.size() != 0) @(posedge clk);
	endtask

	task automatic load_registers(input cfg_t c, input bit noisy);
		logic [CFG_IDX_W-1:0]  idx  [8];
		logic [CFG_DATA_W-1:0] vals [8];
		int n;
		n = noisy ? 8 : 7;
		for (int i = 0; i < 8; i++)
			vals[i] = noisy ? CFG_DATA_W'($urandom) : '0;
		idx[0] = REG_GAIN_P;     vals[0][GAIN_W-1:0]   = c.gain_p;
		idx[1] = REG_GAIN_I;     vals[1][GAIN_W-1:0]   = c.gain_i;
		idx[2] = REG_GAIN_D;     vals[2][GAIN_W-1:0]   = c.gain_d;
		idx[3] = REG_OUT_LIMIT;  vals[3][LIMIT_W-1:0]  = c.output_limit;
		idx[4] = REG_INT_LIMIT;  vals[4][LIMIT_W-1:0]  = c.integral_limit;
		idx[5] = REG_SEP_THRESH; vals[5][THRESH_W-1:0] = c.sep_threshold;
		idx[6] = REG_LOOP_MODE;  vals[6][0]            = c.loop_mode;
		// unmapped index carries noise only and must change nothing
		idx[7] = REG_SPARE;
		for (int i = 0; i < n; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data <= vals[i];
			@(posedge clk);
			while (!cfg.ready) @(posedge clk);
		end
		cfg.valid <= 1'b0;
		active_cfg = c;
		cfg_loads++;
		if (c.loop_mode == MODE_INCREMENTAL)
			incr_loads++;
	endtask

	task automatic test_reset_defaults();
		send_request(CMD_STEP, 16'sd1234, -16'sd50);
		send_request(CMD_CLEAR, 16'sd77, 16'sd3);
	endtask

	task automatic test_positional_directed();
		wait_drained();
		// 1.0, 0.5, 0.25 with a tight integral limit and a 1000 separation band
		load_registers(make_settings(24'sh010000, 24'sh008000, 24'sh004000,
			'1, 31'd100, 16'd1000, MODE_POSITIONAL), 1'b0);
		send_request(CMD_STEP, 16'sd10, 16'sd0);
		send_request(CMD_STEP, 16'sd10, 16'sd4);
		send_request(CMD_STEP, 16'sd200, -16'sd300);
		send_request(CMD_STEP, -16'sd500, 16'sd400);
		send_request(CMD_STEP, 16'sh7FFF, 16'sh8000);
		send_request(CMD_STEP, 16'sh8000, 16'sh7FFF);
		send_request(CMD_STEP, 16'sd0, 16'sd0);
		send_request(CMD_CLEAR, 16'sh7FFF, 16'sh8000);
		send_request(CMD_STEP, 16'sd5, 16'sd3);
		wait_drained();
		// extreme gains against a small output limit; full band still separates |e| = 65535
		load_registers(make_settings(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
			31'd1000, '1, THRESH_RESET, MODE_POSITIONAL), 1'b0);
		send_request(CMD_STEP, 16'sh7FFF, 16'sh8000);
		send_request(CMD_STEP, 16'sh8000, 16'sh7FFF);
		send_request(CMD_STEP, 16'sd100, 16'sd99);
	endtask

	task automatic test_incremental_directed();
		wait_drained();
		load_registers(make_settings(24'sh010000, 24'sh002000, -24'sh008000,
			31'd5000, '1, THRESH_RESET, MODE_INCREMENTAL), 1'b0);
		send_request(CMD_STEP, 16'sd100, 16'sd0);
		send_request(CMD_STEP, 16'sd100, 16'sd50);
		send_request(CMD_STEP, -16'sd200, 16'sd30);
		send_request(CMD_STEP, 16'sh7FFF, 16'sh8000);
		send_request(CMD_STEP, 16'sh8000, 16'sh7FFF);
		send_request(CMD_CLEAR, -16'sd9, 16'sd9);
		send_request(CMD_STEP, 16'sd7, 16'sd7);
	endtask

	task automatic test_zero_limits();
		wait_drained();
		load_registers(make_settings(24'sh030000, -24'sh010000, 24'sh001000,
			'0, '0, '0, MODE_POSITIONAL), 1'b0);
		send_request(CMD_STEP, 16'sd1, 16'sd0);
		send_request(CMD_STEP, -16'sd1, 16'sd0);
		send_request(CMD_STEP, 16'sd0, 16'sd0);
	endtask

	task automatic test_random_regulation(input int target);
		cfg_t c;
		int sent, phase_len, k, r, trk_sp, trk_ms;
		sent = 0;
		while (sent < target) begin
			wait_drained();
			c.gain_p = rand_gain();
			c.gain_i = rand_gain();
			c.gain_d = rand_gain();
			c.output_limit = rand_limit();
			c.integral_limit = rand_limit();
			r = $urandom_range(0, 99);
			if (r < 25)
				c.sep_threshold = THRESH_RESET;
			else if (r < 35)
				c.sep_threshold = '0;
			else if (r < 75)
				c.sep_threshold = THRESH_W'($urandom_range(1, 2000));
			else
				c.sep_threshold = THRESH_W'($urandom_range(0, 65535));
			c.loop_mode = $urandom_range(0, 1) ? MODE_INCREMENTAL : MODE_POSITIONAL;
			load_registers(c, 1'b1);
			trk_sp = int'(rand_sample());
			trk_ms = int'(rand_sample());
			phase_len = $urandom_range(40, 160);
			for (k = 0; k < phase_len && sent < target; k++) begin
				if (k % 50 == 0) begin
					sender_idle = $urandom_range(0, 3) != 0;
					receiver_idle = $urandom_range(0, 3) != 0;
				end
				if ($urandom_range(0, 199) == 0)
					wait_drained();
				r = $urandom_range(0, 99);
				if (r < 3) begin
					send_request(CMD_CLEAR, rand_sample(), rand_sample());
				end else if (r < 63) begin
					// closed-loop style: the measurement creeps toward a held target
					if ($urandom_range(0, 19) == 0)
						trk_sp = int'(rand_sample());
					trk_ms = trk_ms + (trk_sp - trk_ms) / 8 + int'($urandom_range(0, 20)) - 10;
					if (trk_ms > 32767)
						trk_ms = 32767;
					else if (trk_ms < -32768)
						trk_ms = -32768;
					send_request(CMD_STEP, SAMPLE_BITS'(trk_sp), SAMPLE_BITS'(trk_ms));
				end else begin
					send_request(CMD_STEP, rand_sample(), rand_sample());
				end
				sent++;
			end
		end
	endtask

	// Response side: random stalls when enabled
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
			rsp.ready <= 1'b0;
			stall_left = draw_pause();
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			results_checked++;
			if (pending_drives.size() == 0) begin
				$error("result with no request outstanding: drive %0d clamped %0b",
					rsp.drive, rsp.clamped);
				fault_count++;
			end else begin
				oldest = pending_drives.pop_front();
				if (rsp.drive !== oldest.drive) begin
					$error("drive: expected %0d, got %0d", oldest.drive, rsp.drive);
					fault_count++;
				end
				if (rsp.clamped !== oldest.clamped) begin
					$error("clamped: expected %0b, got %0b", oldest.clamped, rsp.clamped);
					fault_count++;
				end
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: %0d cycles without a handshake", QUIET_LIMIT);
		$display("pid_positional_incremental regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_STEP;
		req.setpoint = '0;
		req.measured = '0;
		rsp.ready = 1'b1;
		cfg.valid = 1'b0;
		cfg.index = REG_GAIN_P;
		cfg.data = '0;
		stall_left = 0;
		req_held = 1'b0;
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		active_cfg = make_settings('0, '0, '0, LIMIT_RESET, LIMIT_RESET, THRESH_RESET,
			MODE_POSITIONAL);
		void'(advance_pid(CMD_CLEAR, '0, '0));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_positional_directed();
		test_incremental_directed();
		test_zero_limits();
		test_random_regulation(RANDOM_ITEMS);

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_drives.size() != 0) begin
			$error("%0d expected results never arrived", pending_drives.size());
			fault_count++;
		end
		$display("run covered %0d requests (%0d clears), %0d results checked",
			requests_sent, clears_sent, results_checked);
		$display("over %0d register loads, %0d of them in incremental form, %0d faults",
			cfg_loads, incr_loads, fault_count);
		if (fault_count == 0)
			$display("pid_positional_incremental regression: pass");
		else
			$display("pid_positional_incremental regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
